/* src/nalscan_pkg.sv */
// Shared types, constants and the NAL type decoder of the Annex B unit scanner.
package nalscan_pkg;

    localparam int MAX_UNIT_BYTES = 65535;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] CODEC_AVC  = 2'd0;
    localparam logic [1:0] CODEC_HEVC = 2'd1;
    localparam logic [1:0] CODEC_VVC  = 2'd2;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [5:0] AVC_SEI       = 6'd6;
    localparam logic [5:0] HEVC_SEI_PRE  = 6'd39;
    localparam logic [5:0] HEVC_SEI_SUF  = 6'd40;
    localparam logic [5:0] VVC_SEI_PRE   = 6'd23;
    localparam logic [5:0] VVC_SEI_SUF   = 6'd24;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       area_last;
    } t_in;

    typedef struct packed {
        logic [15:0] unit_index;
        logic [15:0] unit_size;
        logic [1:0]  header_size;
        logic [5:0]  unit_type;
        logic        type_valid;
        logic        is_sei;
        logic        run_last;
    } t_out;

    // One ended unit as the front end sees it, before type decode.
    typedef struct packed {
        logic [15:0] index;
        logic [15:0] size;
        logic [7:0]  hb0;
        logic [7:0]  hb1;
    } t_unit_rec;

    // Everything one byte produced: one or two ended units.
    typedef struct packed {
        logic      two;
        t_unit_rec rec0;
        t_unit_rec rec1;
    } t_q_entry;

    function automatic t_out decode_unit(input logic [1:0] codec, input t_unit_rec rec,
                                         input logic last);
        t_out       res;
        logic [5:0] typ;
        res            = '0;
        res.unit_index = rec.index;
        res.unit_size  = rec.size;
        res.run_last   = last;
        typ            = '0;
        case (codec)
            CODEC_AVC: begin
                if (rec.size != 16'd0) begin
                    typ              = {1'b0, rec.hb0[4:0]};
                    res.header_size  = 2'd1;
                    res.type_valid   = 1'b1;
                    res.unit_type    = typ;
                    res.is_sei       = (typ == AVC_SEI);
                end
            end
            CODEC_HEVC: begin
                if (rec.size != 16'd0) begin
                    typ              = rec.hb0[6:1];
                    res.header_size  = 2'd2;
                    res.type_valid   = 1'b1;
                    res.unit_type    = typ;
                    res.is_sei       = (typ == HEVC_SEI_PRE) || (typ == HEVC_SEI_SUF);
                end
            end
            CODEC_VVC: begin
                if (rec.size > 16'd1) begin
                    typ              = {1'b0, rec.hb1[7:3]};
                    res.header_size  = 2'd2;
                    res.type_valid   = 1'b1;
                    res.unit_type    = typ;
                    res.is_sei       = (typ == VVC_SEI_PRE) || (typ == VVC_SEI_SUF);
                end
            end
            default: begin
                res.header_size = 2'd0;
            end
        endcase
        return res;
    endfunction

endpackage

/* src/nalscan_front.sv */
// Front end: start code hunt, unit delimiting and size counting, one byte per cycle while i_accept is high.
module nalscan_front #(
    parameter int MAX_UNIT_BYTES = nalscan_pkg::MAX_UNIT_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  nalscan_pkg::t_in      i_data,
    output logic                  o_q_push,
    output nalscan_pkg::t_q_entry o_q_entry
);

    localparam int CNT_W = $clog2(MAX_UNIT_BYTES + 3);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_UNIT_BYTES + 2);
    localparam int CAP_INT = (MAX_UNIT_BYTES < 65535) ? MAX_UNIT_BYTES : 65535;
    localparam logic [CNT_W-1:0] SIZE_CAP = CNT_W'(CAP_INT);

    logic             r_in_unit,  n_in_unit;
    logic [1:0]       r_zero_run, n_zero_run;
    logic [CNT_W-1:0] r_body,     n_body;
    logic [7:0]       r_hb0,      n_hb0;
    logic [7:0]       r_hb1,      n_hb1;
    logic [15:0]      r_next_idx, n_next_idx;

    logic                   emit_a, emit_b;
    logic                   is_zero, is_one, run2;
    nalscan_pkg::t_unit_rec rec_a, rec_b;

    function automatic logic [15:0] sat_size(input logic [CNT_W-1:0] body,
                                             input logic [1:0] drop);
        logic [CNT_W-1:0] diff;
        logic [CNT_W-1:0] dropw;
        dropw = CNT_W'(drop);
        diff  = (body >= dropw) ? (body - dropw) : '0;
        if (diff > SIZE_CAP) begin
            diff = SIZE_CAP;
        end
        return 16'(diff);
    endfunction

    always_comb begin
        n_in_unit  = r_in_unit;
        n_zero_run = r_zero_run;
        n_body     = r_body;
        n_hb0      = r_hb0;
        n_hb1      = r_hb1;
        n_next_idx = r_next_idx;
        emit_a     = 1'b0;
        is_zero    = (i_data.data_byte == nalscan_pkg::BYTE_ZERO);
        is_one     = (i_data.data_byte == nalscan_pkg::BYTE_ONE);
        run2       = (r_zero_run >= 2'd2);

        rec_a.index = r_next_idx;
        rec_a.size  = sat_size(r_body, 2'd2);
        rec_a.hb0   = r_hb0;
        rec_a.hb1   = r_hb1;

        if (r_in_unit) begin
            if (is_zero && run2) begin
                // Three zeros close the unit; keep counting toward a start code.
                emit_a     = 1'b1;
                n_in_unit  = 1'b0;
                n_zero_run = 2'd3;
            end else if (is_one && run2) begin
                emit_a     = 1'b1;
                n_in_unit  = 1'b1;
                n_zero_run = '0;
                n_body     = '0;
                n_hb0      = '0;
                n_hb1      = '0;
            end else begin
                n_zero_run = is_zero ? (r_zero_run + 2'd1) : 2'd0;
                if (r_body == CNT_W'(0)) begin
                    n_hb0 = i_data.data_byte;
                end else if (r_body == CNT_W'(1)) begin
                    n_hb1 = i_data.data_byte;
                end
                if (r_body < CNT_TOP) begin
                    n_body = r_body + CNT_W'(1);
                end
            end
        end else begin
            if (is_zero) begin
                if (r_zero_run != 2'd3) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else if (is_one && run2) begin
                n_in_unit  = 1'b1;
                n_zero_run = '0;
                n_body     = '0;
                n_hb0      = '0;
                n_hb1      = '0;
            end else begin
                n_zero_run = '0;
            end
        end

        if (emit_a) begin
            n_next_idx = r_next_idx + 16'd1;
        end

        // End of area flushes a pending unit with its trailing zeros.
        emit_b      = i_data.area_last && n_in_unit;
        rec_b.index = n_next_idx;
        rec_b.size  = sat_size(n_body, 2'd0);
        rec_b.hb0   = n_hb0;
        rec_b.hb1   = n_hb1;

        if (i_data.area_last) begin
            n_in_unit  = 1'b0;
            n_zero_run = '0;
            n_body     = '0;
            n_hb0      = '0;
            n_hb1      = '0;
            n_next_idx = '0;
        end

        o_q_entry.two  = emit_a && emit_b;
        o_q_entry.rec0 = emit_a ? rec_a : rec_b;
        o_q_entry.rec1 = rec_b;
        o_q_push       = i_accept && (emit_a || emit_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_unit  <= 1'b0;
            r_zero_run <= '0;
            r_body     <= '0;
            r_hb0      <= '0;
            r_hb1      <= '0;
            r_next_idx <= '0;
        end else if (i_accept) begin
            r_in_unit  <= n_in_unit;
            r_zero_run <= n_zero_run;
            r_body     <= n_body;
            r_hb0      <= n_hb0;
            r_hb1      <= n_hb1;
            r_next_idx <= n_next_idx;
        end
    end

endmodule

/* src/nalscan_queue.sv */
// Short register queue between the front end and the result stage.
module nalscan_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  nalscan_pkg::t_q_entry i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_empty,
    output nalscan_pkg::t_q_entry o_entry
);

    localparam int DEPTH = nalscan_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nalscan_pkg::t_q_entry r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]      r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == CNT_W'(0));
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : (r_wr_ptr + PTR_W'(1));
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : (r_rd_ptr + PTR_W'(1));
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* src/nalscan_back.sv */
// Result stage: type decode and output register, one or two results per entry.
module nalscan_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_codec,
    input  logic                  i_q_empty,
    input  nalscan_pkg::t_q_entry i_q_entry,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output nalscan_pkg::t_out     o_data
);

    logic              r_valid, n_valid;
    logic              r_second, n_second;
    nalscan_pkg::t_out r_out, n_out;
    logic              load;

    assign load = !r_valid || i_pop;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_out    = r_out;
        o_q_pop  = 1'b0;
        if (load) begin
            n_valid = !i_q_empty;
            if (!i_q_empty) begin
                if (!r_second) begin
                    n_out = nalscan_pkg::decode_unit(i_codec, i_q_entry.rec0, !i_q_entry.two);
                    if (i_q_entry.two) begin
                        n_second = 1'b1;
                    end else begin
                        o_q_pop = 1'b1;
                    end
                end else begin
                    n_out    = nalscan_pkg::decode_unit(i_codec, i_q_entry.rec1, 1'b1);
                    n_second = 1'b0;
                    o_q_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty = !r_valid;
    assign o_data  = r_out;

endmodule

/* src/annexb_nal_unit_scanner_unit.sv */
// Top level of the Annex B NAL unit scanner: front end, queue, result stage, codec register.
//
// Input channel: present one byte of the data area on i_data with push; a transaction
// completes at a rising edge with push high and full low. Mark the final byte of an area
// with area_last; the scan state (unit count included) then clears for the next area.
// Result channel: while empty is low, o_data holds the oldest NAL unit report; pop takes it.
// Each byte yields zero, one or two reports; run_last flags the final one of a byte.
// Configuration: write the codec format (0 AVC, 1 HEVC, 2 VVC) through i_cfg_valid /
// i_cfg_data; o_cfg_ready is always high. Write it only while the block is idle.
// Throughput: one byte per cycle while full is low, set by the zero-run tracker in the
// front end. A byte that closes a unit and also ends the area gives two reports, which
// leave the output register in turn.
// Path: the front end queues a byte's reports; the result stage registers them for output.
// Stall: a four-entry queue (an entry per byte with reports) parts the front end from the
// output register; when pop stays low, the queue fills and full rises until reports drain.
// Reset (synchronous, active low): clears the scan state, the queue, the output valid and
// sets the codec format to AVC.
module annexb_nal_unit_scanner_unit #(
    parameter int MAX_UNIT_BYTES = nalscan_pkg::MAX_UNIT_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  nalscan_pkg::t_in  i_data,
    output logic              empty,
    input  logic              pop,
    output nalscan_pkg::t_out o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_data
);

    logic [1:0]            r_codec;
    logic                  in_accept;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    nalscan_pkg::t_q_entry q_wr_entry;
    nalscan_pkg::t_q_entry q_rd_entry;

    // Codec register: always ready, written whenever the transaction completes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= nalscan_pkg::CODEC_AVC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_codec <= i_cfg_data;
        end
    end

    // Hold off the input side only when the queue has no room.
    assign full      = q_full;
    assign in_accept = push && !q_full;

    nalscan_front #(
        .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_data    (i_data),
        .o_q_push  (q_push),
        .o_q_entry (q_wr_entry)
    );

    nalscan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_rd_entry)
    );

    // Type decode uses the current codec; the user changes it only while idle; not enforced.
    nalscan_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_codec   (r_codec),
        .i_q_empty (q_empty),
        .i_q_entry (q_rd_entry),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (o_data)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("front end pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("result stage popped an empty queue");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_data.run_last) |=> !empty)
        else $error("second report of a byte did not follow at once");

    a_invalid_type_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.type_valid) |->
            (o_data.unit_type == 6'd0 && !o_data.is_sei && o_data.header_size == 2'd0))
        else $error("undecoded unit carries type fields");
`endif

endmodule

/* sim/annexb_nal_unit_scanner_unit_tb.sv */
// Self-checking testbench for the Annex B NAL unit scanner: directed, random and long-unit traffic.
module annexb_nal_unit_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transaction on any channel before the run is declared hung.
    // Random gaps on either side and the idle pause before a codec write
    // stay well below this limit, which leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    // Idle wait before a codec write and at the end, once every expected report is out.
    localparam int DRAIN_CYCLES   = 6;
    // Well-formed bytes per random phase; with directed bytes, noise and the long
    // unit, six phases give about 1400 bytes.
    localparam int PHASE_BYTES    = 210;
    // Body length of the one long unit.
    localparam int LONG_BODY      = 100;

    // Scoreboard: tracks the scan state of the block, predicts the unit reports
    // of each accepted byte and checks them in order against what the block pops.
    class nal_report_board;
        logic [1:0]         codec;
        logic               in_unit;
        logic [1:0]         zero_run;
        logic [16:0]        body_count;
        logic [7:0]         hdr0;
        logic [7:0]         hdr1;
        logic [15:0]        unit_count;
        nalscan_pkg::t_out  expected_reports[$];
        int                 errors;
        int                 reports_checked;

        function new();
            codec           = nalscan_pkg::CODEC_AVC;
            errors          = 0;
            reports_checked = 0;
            clear_area();
        endfunction

        function void clear_area();
            in_unit    = 1'b0;
            zero_run   = '0;
            body_count = '0;
            hdr0       = '0;
            hdr1       = '0;
            unit_count = '0;
        endfunction

        function void open_unit();
            in_unit    = 1'b1;
            zero_run   = '0;
            body_count = '0;
            hdr0       = '0;
            hdr1       = '0;
        endfunction

        // Build the report of the unit now ending, dropping terminator zeros.
        function nalscan_pkg::t_out close_unit(logic [16:0] drop);
            nalscan_pkg::t_out r;
            logic [16:0]       size;
            size = (body_count >= drop) ? body_count - drop : '0;
            if (size > 17'(nalscan_pkg::MAX_UNIT_BYTES))
                size = 17'(nalscan_pkg::MAX_UNIT_BYTES);
            if (size > 17'd65535)
                size = 17'd65535;
            r            = '0;
            r.unit_index = unit_count;
            r.unit_size  = size[15:0];
            case (codec)
                nalscan_pkg::CODEC_AVC: begin
                    if (size >= 17'd1) begin
                        r.header_size = 2'd1;
                        r.type_valid  = 1'b1;
                        r.unit_type   = {1'b0, hdr0[4:0]};
                        r.is_sei      = (r.unit_type == nalscan_pkg::AVC_SEI);
                    end
                end
                nalscan_pkg::CODEC_HEVC: begin
                    if (size >= 17'd1) begin
                        r.header_size = 2'd2;
                        r.type_valid  = 1'b1;
                        r.unit_type   = hdr0[6:1];
                        r.is_sei      = (r.unit_type == nalscan_pkg::HEVC_SEI_PRE) ||
                                        (r.unit_type == nalscan_pkg::HEVC_SEI_SUF);
                    end
                end
                nalscan_pkg::CODEC_VVC: begin
                    if (size >= 17'd2) begin
                        r.header_size = 2'd2;
                        r.type_valid  = 1'b1;
                        r.unit_type   = {1'b0, hdr1[7:3]};
                        r.is_sei      = (r.unit_type == nalscan_pkg::VVC_SEI_PRE) ||
                                        (r.unit_type == nalscan_pkg::VVC_SEI_SUF);
                    end
                end
                default: ;
            endcase
            unit_count = unit_count + 16'd1;
            return r;
        endfunction

        function void note_byte(nalscan_pkg::t_in item);
            nalscan_pkg::t_out batch[2];
            int                n;
            n = 0;
            if (in_unit) begin
                if (item.data_byte == nalscan_pkg::BYTE_ZERO && zero_run >= 2'd2) begin
                    batch[n] = close_unit(17'd2);
                    n++;
                    in_unit  = 1'b0;
                    zero_run = 2'd3;
                end else if (item.data_byte == nalscan_pkg::BYTE_ONE && zero_run >= 2'd2) begin
                    batch[n] = close_unit(17'd2);
                    n++;
                    open_unit();
                end else begin
                    zero_run = (item.data_byte == nalscan_pkg::BYTE_ZERO) ? zero_run + 2'd1
                                                                          : 2'd0;
                    if (body_count == 17'd0)
                        hdr0 = item.data_byte;
                    else if (body_count == 17'd1)
                        hdr1 = item.data_byte;
                    if (body_count < 17'(nalscan_pkg::MAX_UNIT_BYTES + 2))
                        body_count = body_count + 17'd1;
                end
            end else begin
                if (item.data_byte == nalscan_pkg::BYTE_ZERO) begin
                    if (zero_run < 2'd3)
                        zero_run = zero_run + 2'd1;
                end else if (item.data_byte == nalscan_pkg::BYTE_ONE && zero_run >= 2'd2) begin
                    open_unit();
                end else begin
                    zero_run = '0;
                end
            end
            if (item.area_last) begin
                if (in_unit) begin
                    batch[n] = close_unit(17'd0);
                    n++;
                end
                clear_area();
            end
            if (n > 0)
                batch[n - 1].run_last = 1'b1;
            for (int k = 0; k < n; k++)
                expected_reports.push_back(batch[k]);
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("report %0d field %s: got %0d, expected %0d",
                                 reports_checked, name, got, want));
        endtask

        task check_report(nalscan_pkg::t_out got);
            nalscan_pkg::t_out want;
            if (expected_reports.size() == 0) begin
                report($sformatf("unexpected report: index %0d size %0d",
                                 got.unit_index, got.unit_size));
            end else begin
                want = expected_reports.pop_front();
                check_field("unit_index",  got.unit_index,  want.unit_index);
                check_field("unit_size",   got.unit_size,   want.unit_size);
                check_field("header_size", got.header_size, want.header_size);
                check_field("unit_type",   got.unit_type,   want.unit_type);
                check_field("type_valid",  got.type_valid,  want.type_valid);
                check_field("is_sei",      got.is_sei,      want.is_sei);
                check_field("run_last",    got.run_last,    want.run_last);
                reports_checked++;
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    nalscan_pkg::t_in  i_data;
    logic              empty;
    logic              pop;
    nalscan_pkg::t_out o_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_data;

    nal_report_board board;
    logic [7:0]      area_buf[$];
    int              send_idle_pct;
    int              recv_idle_pct;
    int              stall_cycles;
    int              bytes_accepted;
    int              areas_sent;

    annexb_nal_unit_scanner_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock, low for the first half period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: pick pop at every falling edge; a zero idle rate keeps pop high.
    always @(negedge i_clk) begin
        pop = ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: sample every channel at the rising edge, before the block's
    // registers move. Check pops first; a byte's reports never leave in the
    // cycle that the byte enters, so the order of the two does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                board.check_report(o_data);
            if (push && !full) begin
                board.note_byte(i_data);
                bytes_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready)
                board.codec = i_cfg_data;
            // Watchdog: any transaction restarts the count.
            if ((pop && !empty) || (push && !full) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("annexb_nal_unit_scanner_unit regression: fail");
                $finish;
            end
        end
    end

    // Present one byte at a falling edge, after a random gap, and hold it until
    // the block takes it. Push stays high on return; the caller's next falling
    // edge either replaces the byte or drops push.
    task automatic send_byte(input logic [7:0] value, input logic is_final);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push             = 1'b1;
        i_data.data_byte = value;
        i_data.area_last = is_final;
        do @(posedge i_clk); while (full);
    endtask

    // Send the buffered area, marking its final byte as the end of the area.
    task automatic flush_area();
        for (int k = 0; k < area_buf.size(); k++)
            send_byte(area_buf[k], k == area_buf.size() - 1);
        area_buf.delete();
        areas_sent++;
    endtask

    task automatic end_traffic();
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // Write the codec format once the block is idle: every expected report
    // out, then the drain wait for a byte that is still in flight but
    // causes no report.
    task automatic write_codec(input logic [1:0] fmt);
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = fmt;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Header byte for the current codec; a quarter of those at the type position carry an SEI type.
    function automatic logic [7:0] header_byte(int pos);
        logic [7:0] v;
        bit         sei;
        bit         pick_pre;
        v        = 8'($urandom_range(255));
        sei      = ($urandom_range(3) == 0);
        pick_pre = 1'($urandom_range(1));
        case (board.codec)
            nalscan_pkg::CODEC_AVC:
                if (pos == 0 && sei) v[4:0] = nalscan_pkg::AVC_SEI[4:0];
            nalscan_pkg::CODEC_HEVC:
                if (pos == 0 && sei)
                    v[6:1] = pick_pre ? nalscan_pkg::HEVC_SEI_PRE : nalscan_pkg::HEVC_SEI_SUF;
            nalscan_pkg::CODEC_VVC:
                if (pos == 1 && sei)
                    v[7:3] = pick_pre ? nalscan_pkg::VVC_SEI_PRE[4:0]
                                      : nalscan_pkg::VVC_SEI_SUF[4:0];
            default: ;
        endcase
        return v;
    endfunction

    // Build one well-formed area: optional junk, one to four units with random
    // headers and bodies, and one of the four ways an area can end.
    task automatic build_area();
        int units;
        int hdr_len;
        int body_len;
        units = $urandom_range(1, 4);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) area_buf.push_back(8'($urandom_range(255)));
        repeat (units) begin
            if ($urandom_range(1))
                area_buf.push_back(nalscan_pkg::BYTE_ZERO);
            area_buf.push_back(nalscan_pkg::BYTE_ZERO);
            area_buf.push_back(nalscan_pkg::BYTE_ZERO);
            area_buf.push_back(nalscan_pkg::BYTE_ONE);
            // Mostly full headers; short ones hit the undecoded type paths.
            hdr_len = $urandom_range(9);
            hdr_len = (hdr_len > 2) ? 2 : hdr_len;
            for (int p = 0; p < hdr_len; p++)
                area_buf.push_back(header_byte(p));
            body_len = ($urandom_range(7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
            repeat (body_len)
                area_buf.push_back(($urandom_range(5) == 0) ? nalscan_pkg::BYTE_ZERO
                                                            : 8'($urandom_range(255)));
        end
        case ($urandom_range(3))
            0: ;
            1: repeat ($urandom_range(1, 2)) area_buf.push_back(nalscan_pkg::BYTE_ZERO);
            2: begin
                area_buf.push_back(nalscan_pkg::BYTE_ZERO);
                area_buf.push_back(nalscan_pkg::BYTE_ZERO);
                area_buf.push_back(nalscan_pkg::BYTE_ONE);
            end
            default: repeat (3) area_buf.push_back(nalscan_pkg::BYTE_ZERO);
        endcase
    endtask

    // Noise: a short burst of random bytes, rich in zeros and ones, that may
    // end an area anywhere.
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(3))
                0:       b = nalscan_pkg::BYTE_ZERO;
                1:       b = nalscan_pkg::BYTE_ONE;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, $urandom_range(9) == 0);
        end
    endtask

    // One random phase under a given codec and idle mix. Noise bytes do not
    // count toward the phase length.
    task automatic run_phase(input int send_pct, input int recv_pct, input logic [1:0] fmt);
        int counted;
        write_codec(fmt);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted       = 0;
        while (counted < PHASE_BYTES) begin
            if ($urandom_range(4) == 0) begin
                send_noise();
            end else begin
                build_area();
                counted += area_buf.size();
                flush_area();
            end
        end
        end_traffic();
    endtask

    initial begin
        board          = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_data         = '0;
        pop            = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = nalscan_pkg::CODEC_AVC;
        send_idle_pct  = 26;
        recv_idle_pct  = 49;
        stall_cycles   = 0;
        bytes_accepted = 0;
        areas_sent     = 0;

        // Hold reset, then release it at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: AVC, with the first idle mix.
        write_codec(nalscan_pkg::CODEC_AVC);
        // SEI unit ended by a start code, unit ended by three zeros, new unit
        // opened from the trailing zero run, then a unit closed by a start code
        // on the final byte, which also reports an empty unit.
        area_buf = '{8'h00, 8'h00, 8'h01, 8'h06, 8'hAA, 8'h00, 8'h00, 8'h01, 8'h65,
                     8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01};
        flush_area();
        // Area end with trailing zeros kept in the unit.
        area_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        flush_area();
        // Area end with no unit open: no report.
        area_buf = '{8'h7F, 8'hFF};
        flush_area();
        end_traffic();

        // Random: receiver-heavy idling, then sender-heavy, then none, walking
        // the codec through every format, the undefined fourth one included.
        run_phase(26, 49, nalscan_pkg::CODEC_HEVC);
        run_phase(26, 49, nalscan_pkg::CODEC_VVC);
        run_phase(49, 26, 2'd3);
        run_phase(49, 26, nalscan_pkg::CODEC_AVC);
        run_phase(0, 0, nalscan_pkg::CODEC_VVC);
        run_phase(0, 0, nalscan_pkg::CODEC_HEVC);

        // One long unit ended by a start code, then a short unit closed by the
        // end of the area.
        write_codec(nalscan_pkg::CODEC_AVC);
        area_buf = '{8'h00, 8'h00, 8'h01};
        repeat (LONG_BODY) area_buf.push_back(8'($urandom_range(2, 255)));
        area_buf.push_back(nalscan_pkg::BYTE_ZERO);
        area_buf.push_back(nalscan_pkg::BYTE_ZERO);
        area_buf.push_back(nalscan_pkg::BYTE_ONE);
        area_buf.push_back(8'h09);
        area_buf.push_back(8'h10);
        flush_area();
        end_traffic();

        // Drain: wait out every expected report, then watch through the drain
        // wait for anything extra.
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d bytes in %0d areas plus noise, AVC, HEVC, VVC and undefined format,",
                 bytes_accepted, areas_sent);
        $display("both sides stalling; %0d unit reports checked, %0d mismatches.",
                 board.reports_checked, board.errors);
        if (board.errors == 0)
            $display("annexb_nal_unit_scanner_unit regression: pass");
        else
            $display("annexb_nal_unit_scanner_unit regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/nalscan_pkg.sv
src/nalscan_front.sv
src/nalscan_queue.sv
src/nalscan_back.sv
src/annexb_nal_unit_scanner_unit.sv
sim/annexb_nal_unit_scanner_unit_tb.sv
